// ===== hdl/msgd_pkg.sv =====
`default_nettype none

package msgd_pkg;

  // Velocity store depth and address width
  localparam int PARAM_COUNT = 4096;
  localparam int ADDR_W      = $clog2(PARAM_COUNT);

  // Fixed field widths
  localparam int IDX_W     = 12;
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 24;
  localparam int RATE_W    = 25;
  localparam int LIM_W     = 31;
  localparam int CFG_IDX_W = 2;

  // Gradient after decay add: |g| < 1.5 * 2^32, needs 34 signed bits
  localparam int G_W = 34;

  // Front/back queue depth
  localparam int QUEUE_DEPTH = 4;

  // Register reset values
  localparam logic [RATE_W-1:0] LR_RESET    = RATE_W'(167772);
  localparam logic [RATE_W-1:0] MOM_RESET   = RATE_W'(15099494);
  localparam logic [RATE_W-1:0] DECAY_RESET = '0;
  localparam logic [LIM_W-1:0]  CLIP_RESET  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE       = 2'd0,
    CFG_MOMENTUM_FACTOR = 2'd1,
    CFG_DECAY_FACTOR    = 2'd2,
    CFG_CLIP_LIMIT      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [RATE_W-1:0] step_size;
    logic [RATE_W-1:0] momentum_factor;
    logic [RATE_W-1:0] decay_factor;
    logic [LIM_W-1:0]  clip_limit;
  } cfg_t;

  // One classified item handed from front to back
  typedef struct packed {
    logic        [IDX_W-1:0]  idx;
    logic signed [DATA_W-1:0] val;
    logic signed [G_W-1:0]    grad;
  } work_t;

endpackage

`default_nettype wire

// ===== hdl/msgd_ram.sv =====
`default_nettype none

module msgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/msgd_front.sv =====
`default_nettype none

module msgd_front
  import msgd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     enable,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic        [IDX_W-1:0]  param_index,
  input  logic signed [DATA_W-1:0] gradient,
  input  logic signed [DATA_W-1:0] param_value,
  input  logic                     is_bias,
  output logic                     push_valid,
  input  logic                     push_ready,
  output work_t                    push_item
);

  localparam int PROD_W = RATE_W + 1 + DATA_W;

  // Stage 1: decay product
  logic                     f1_valid;
  logic        [IDX_W-1:0]  f1_idx;
  logic signed [DATA_W-1:0] f1_grad;
  logic signed [DATA_W-1:0] f1_val;
  logic                     f1_bias;
  logic signed [PROD_W-1:0] f1_prod;

  // Stage 2: decayed gradient
  logic                     f2_valid;
  logic        [IDX_W-1:0]  f2_idx;
  logic signed [DATA_W-1:0] f2_val;
  logic signed [G_W-1:0]    f2_g;

  logic                     f1_ready;
  logic                     f2_ready;
  logic                     accept;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [G_W-1:0]    decay_term;
  logic signed [G_W-1:0]    g_sum;

  logic                     clip_on;
  logic signed [G_W-1:0]    lim_s;
  logic signed [G_W-1:0]    g_cl;
  logic        [G_W-1:0]    mag;
  logic        [G_W+2:0]    mag5;
  logic        [G_W+2:0]    lim3;
  logic signed [G_W-1:0]    g_inc;
  logic signed [G_W-1:0]    g_half;

  assign f2_ready = !f2_valid || push_ready;
  assign f1_ready = !f1_valid || f2_ready;
  assign in_ready = f1_ready && enable;
  assign accept   = in_valid && in_ready;

  // Round to nearest, ties up, then drop the fraction
  assign prod_rnd   = f1_prod + (PROD_W'(1) << (FRAC_W - 1));
  assign decay_term = $signed(prod_rnd[FRAC_W +: G_W]);
  assign g_sum      = G_W'(f1_grad) + (f1_bias ? G_W'(0) : decay_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (f1_ready) begin
        f1_valid <= accept;
      end
      if (f2_ready) begin
        f2_valid <= f1_valid;
      end
    end
    if (accept) begin
      f1_idx  <= param_index;
      f1_grad <= gradient;
      f1_val  <= param_value;
      f1_bias <= is_bias;
      f1_prod <= $signed({1'b0, cfg.decay_factor}) * param_value;
    end
    if (f1_valid && f2_ready) begin
      f2_idx <= f1_idx;
      f2_val <= f1_val;
      f2_g   <= g_sum;
    end
  end

  // Clamp when a limit is set, then halve when |g| > 0.6 * limit (exact: 5|g| > 3 limit)
  assign clip_on = |cfg.clip_limit;
  assign lim_s   = $signed({{(G_W-LIM_W){1'b0}}, cfg.clip_limit});

  always_comb begin
    if (clip_on && (f2_g > lim_s)) begin
      g_cl = lim_s;
    end else if (clip_on && (f2_g < -lim_s)) begin
      g_cl = -lim_s;
    end else begin
      g_cl = f2_g;
    end
  end

  assign mag    = g_cl[G_W-1] ? G_W'(-g_cl) : G_W'(g_cl);
  assign mag5   = {3'b000, mag} + {1'b0, mag, 2'b00};
  assign lim3   = {{(G_W+3-LIM_W){1'b0}}, cfg.clip_limit}
                + {{(G_W+2-LIM_W){1'b0}}, cfg.clip_limit, 1'b0};
  assign g_inc  = g_cl + G_W'(1);
  assign g_half = g_inc >>> 1;

  assign push_valid     = f2_valid;
  assign push_item.idx  = f2_idx;
  assign push_item.val  = f2_val;
  assign push_item.grad = (mag5 > lim3) ? g_half : g_cl;

endmodule

`default_nettype wire

// ===== hdl/msgd_queue.sv =====
`default_nettype none

module msgd_queue
  import msgd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  work_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign push_ready = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/msgd_back.sv =====
`default_nettype none

module msgd_back
  import msgd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  output logic                     clearing,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  work_t                    q_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic        [IDX_W-1:0]  out_index,
  output logic signed [DATA_W-1:0] new_value,
  output logic signed [DATA_W-1:0] new_velocity
);

  localparam int LRG_W = RATE_W + 1 + G_W;
  localparam int MV_W  = RATE_W + 1 + DATA_W;
  localparam int SUM_W = LRG_W + 1;
  localparam int VEL_W = SUM_W - FRAC_W;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [VEL_W-1:0] x);
    logic [VEL_W-DATA_W:0] hi;
    hi = x[VEL_W-1:DATA_W-1];
    if ((hi == '0) || (hi == '1)) begin
      return x[DATA_W-1:0];
    end else if (x[VEL_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  logic [ADDR_W-1:0]        clr_addr;

  logic                     s1_valid;
  logic        [IDX_W-1:0]  s1_idx;
  logic signed [DATA_W-1:0] s1_val;
  logic signed [LRG_W-1:0]  s1_lrg;

  logic                     s2_valid;
  logic        [IDX_W-1:0]  s2_idx;
  logic signed [DATA_W-1:0] s2_val;
  logic signed [MV_W-1:0]   s2_mv;
  logic signed [LRG_W-1:0]  s2_lrg;

  // Last item write, covers the read issued in the same cycle
  logic                     fwd_valid;
  logic [ADDR_W-1:0]        fwd_addr;
  logic signed [DATA_W-1:0] fwd_vel;

  logic signed [DATA_W-1:0] out_val;

  logic                     adv;
  logic                     hazard;
  logic                     pop;
  logic signed [DATA_W-1:0] ram_rdata;
  logic signed [DATA_W-1:0] v_old;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DATA_W-1:0] vel;
  logic                     item_we;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic signed [DATA_W-1:0] ram_wdata;
  logic signed [DATA_W:0]   nv_wide;

  assign adv     = !out_valid || out_ready;
  // same entry one stage ahead: its write lands too late for this read
  assign hazard  = s1_valid && (s1_idx[ADDR_W-1:0] == q_item.idx[ADDR_W-1:0]);
  assign pop     = adv && q_valid && !hazard && !clearing;
  assign q_ready = pop;

  assign item_we   = s2_valid && adv;
  assign ram_we    = clearing || item_we;
  assign ram_waddr = clearing ? clr_addr : s2_idx[ADDR_W-1:0];
  assign ram_wdata = clearing ? '0 : vel;

  msgd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (PARAM_COUNT)
  ) u_vel_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (q_item.idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign v_old = (fwd_valid && (fwd_addr == s1_idx[ADDR_W-1:0])) ? fwd_vel : ram_rdata;

  assign sum = SUM_W'(s2_mv) + SUM_W'(s2_lrg) + (SUM_W'(1) << (FRAC_W - 1));
  assign vel = sat_data($signed(sum[FRAC_W +: VEL_W]));

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(PARAM_COUNT - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (adv) begin
        s1_valid  <= pop;
        s2_valid  <= s1_valid;
        fwd_valid <= s2_valid;
        out_valid <= s2_valid;
      end
    end
    if (pop) begin
      s1_idx <= q_item.idx;
      s1_val <= q_item.val;
      s1_lrg <= $signed({1'b0, cfg.step_size}) * q_item.grad;
    end
    if (adv && s1_valid) begin
      s2_idx <= s1_idx;
      s2_val <= s1_val;
      s2_mv  <= $signed({1'b0, cfg.momentum_factor}) * v_old;
      s2_lrg <= s1_lrg;
    end
    if (item_we) begin
      fwd_addr     <= s2_idx[ADDR_W-1:0];
      fwd_vel      <= vel;
      out_index    <= s2_idx;
      out_val      <= s2_val;
      new_velocity <= vel;
    end
  end

  assign nv_wide   = (DATA_W+1)'(out_val) - (DATA_W+1)'(new_velocity);
  assign new_value = sat_data(VEL_W'(nv_wide));

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> !clearing)
    else $error("item in flight during velocity clear");

  a_pop_fills_s1: assert property (@(posedge clk) disable iff (rst)
    pop |=> s1_valid)
    else $error("popped item lost before stage 1");

  a_fwd_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(fwd_valid) |-> $past(item_we))
    else $error("forward entry without a velocity write");

endmodule

`default_nettype wire

// ===== hdl/momentum_sgd_param_update.sv =====
// Channel   Dir  Handshake              Payload
// input     in   in_valid / in_ready    param_index, gradient, param_value, is_bias
// result    out  out_valid / out_ready  out_index, new_value, new_velocity
// config    in   cfg_we (no wait)       cfg_index, cfg_data
//
// One item per cycle sustained while no back-pressure or same-index wait holds it.
// Path: two front stages, queue, two back stages, output register.
// Rate is set by the single-port-write velocity RAM: one read and one write per cycle.
// An item whose index matches the item one back stage ahead waits for it to move on.
// After reset all 4096 velocity RAM entries are cleared, one entry a cycle, with
// in_ready low; configuration writes are taken throughout.
// Front and back stall on their own; the 4-entry queue takes up the slack.
`default_nettype none

module momentum_sgd_param_update
  import msgd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [LIM_W-1:0]         cfg_data,
  // input items
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic        [IDX_W-1:0]  param_index,
  input  logic signed [DATA_W-1:0] gradient,
  input  logic signed [DATA_W-1:0] param_value,
  input  logic                     is_bias,
  // result items
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic        [IDX_W-1:0]  out_index,
  output logic signed [DATA_W-1:0] new_value,
  output logic signed [DATA_W-1:0] new_velocity
);

  cfg_t  cfg;
  logic  clearing;
  logic  push_valid;
  logic  push_ready;
  work_t push_item;
  logic  q_valid;
  logic  q_ready;
  work_t q_item;

  // Config registers; the user must write them only while the block is idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_size       <= LR_RESET;
      cfg.momentum_factor <= MOM_RESET;
      cfg.decay_factor    <= DECAY_RESET;
      cfg.clip_limit      <= CLIP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEP_SIZE:       cfg.step_size       <= cfg_data[RATE_W-1:0];
        CFG_MOMENTUM_FACTOR: cfg.momentum_factor <= cfg_data[RATE_W-1:0];
        CFG_DECAY_FACTOR:    cfg.decay_factor    <= cfg_data[RATE_W-1:0];
        CFG_CLIP_LIMIT:      cfg.clip_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: weight decay (skipped for bias items), clamp and halving of the gradient
  msgd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .enable      (!clearing),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .param_index (param_index),
    .gradient    (gradient),
    .param_value (param_value),
    .is_bias     (is_bias),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  msgd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Back: velocity read-modify-write and result register
  msgd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .clearing     (clearing),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_index    (out_index),
    .new_value    (new_value),
    .new_velocity (new_velocity)
  );

endmodule

`default_nettype wire
